FILE: hw/rtl/prl_pkg.sv
// shared constants and types for the pretrigger page ring logger
// no dependencies; imported by every module of the block
package prl_pkg;

  localparam int PRL_PAGE_BYTES     = 256;
  localparam int PRL_MAX_RING_PAGES = 16;

  // command codes carried in the input tuser
  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_PUSH   = 3'd1;
  localparam logic [2:0] MODE_LAUNCH = 3'd2;
  localparam logic [2:0] MODE_DONE   = 3'd3;
  localparam logic [2:0] MODE_FAIL   = 3'd4;
  localparam logic [2:0] MODE_FINAL  = 3'd5;
  localparam logic [2:0] MODE_READ   = 3'd6;
  localparam logic [2:0] MODE_NOP    = 3'd7;

  // logger states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PAD   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_RING_PAGES = 3'd0;
  localparam logic [2:0] CFG_PRE_PAGES  = 3'd1;
  localparam logic [2:0] CFG_REC_BYTES  = 3'd2;
  localparam logic [2:0] CFG_RECS_PAGE  = 3'd3;
  localparam logic [2:0] CFG_POOL_BASE  = 3'd4;
  localparam logic [2:0] CFG_POOL_END   = 3'd5;

  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // status of the serial remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

FILE: hw/rtl/prl_ring_mem.sv
// byte-wide ring memory, one write port and one registered read port
// depends on prl_pkg for the default geometry
module prl_ring_mem
  import prl_pkg::*;
#(
  parameter int PAGE_BYTES     = PRL_PAGE_BYTES,
  parameter int MAX_RING_PAGES = PRL_MAX_RING_PAGES,
  localparam int DEPTH = PAGE_BYTES * MAX_RING_PAGES,
  localparam int ADDRW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ADDRW-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [ADDRW-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/prl_mod_unit.sv
// serial remainder of a 32-bit count by the ring page count, one bit a cycle
// depends on prl_pkg for the status struct and default geometry
module prl_mod_unit
  import prl_pkg::*;
#(
  parameter int MAX_RING_PAGES = PRL_MAX_RING_PAGES,
  localparam int PW   = $clog2(MAX_RING_PAGES + 1),
  localparam int IDXW = $clog2(MAX_RING_PAGES)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [31:0]     num,
  input  logic [PW-1:0]   den,
  output mod_status_t     status,
  output logic [IDXW-1:0] rem
);

  logic [31:0]   num_r, num_nxt;
  logic [PW-1:0] den_r, den_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [PW:0]   trial;

  // one restoring step per cycle
  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[31]};
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        trial = trial - {1'b0, den_r};
      end
      rem_nxt = trial[PW-1:0];
      num_nxt = {num_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign rem         = rem_r[IDXW-1:0];

endmodule

FILE: hw/rtl/pretrigger_page_ring_logger.sv
// pretrigger page ring logger: non-read commands answer in the cycle after the transfer; a read
// goes through the memory's read register and the ENG_RD state, then the output register
// a push that closes a page, and finalize, write the page tail at one byte a cycle
// start fills the pages in use; writing ring_page_count re-derives the slots by serial remainder
// pushes wait out fills (one write port), re-derives, output stalls; else 1 push per cycle
// synchronous active-low reset: idle state, counters zero, registers at their defaults
module pretrigger_page_ring_logger
  import prl_pkg::*;
#(
  parameter int PAGE_BYTES     = PRL_PAGE_BYTES,
  parameter int MAX_RING_PAGES = PRL_MAX_RING_PAGES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // data_byte, byte_offset
  input  logic [2:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  // read_data, page_ready, flash_address, log_state, dropped_records,
  // failed_pages, records_logged, zero fill
  output logic [143:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int DEPTH = PAGE_BYTES * MAX_RING_PAGES;
  localparam int ADDRW = $clog2(DEPTH);
  localparam int OFFW  = $clog2(PAGE_BYTES);
  localparam int IDXW  = $clog2(MAX_RING_PAGES);
  localparam int PW    = $clog2(MAX_RING_PAGES + 1);

  localparam logic [2:0] ENG_IDLE   = 3'd0;
  localparam logic [2:0] ENG_RD     = 3'd1;
  localparam logic [2:0] ENG_FILL   = 3'd2;
  localparam logic [2:0] ENG_MODH_G = 3'd3;
  localparam logic [2:0] ENG_MODH_W = 3'd4;
  localparam logic [2:0] ENG_MODD_G = 3'd5;
  localparam logic [2:0] ENG_MODD_W = 3'd6;

  // configuration registers
  logic [4:0]  rpc_r, pre_r;
  logic [7:0]  rbytes_r, rpp_r;
  logic [31:0] base_r, pend_r;

  // logger state
  logic [1:0]      state_r, state_nxt;
  logic [31:0]     head_r, head_nxt, drain_r, drain_nxt;
  logic [7:0]      slot_r, slot_nxt, bir_r, bir_nxt;
  logic [31:0]     flash_r, flash_nxt, drop_r, drop_nxt;
  logic [31:0]     fail_r, fail_nxt, total_r, total_nxt;
  logic [IDXW-1:0] hidx_r, hidx_nxt, didx_r, didx_nxt;
  logic            stale_r, stale_nxt;
  logic [2:0]      eng_r, eng_nxt;
  logic [IDXW-1:0] fidx_r, fidx_nxt, flast_r, flast_nxt;
  logic [OFFW-1:0] foff_r, foff_nxt;
  logic            rdz_r, rdz_nxt;

  // output register
  logic         out_valid_r, out_valid_nxt;
  logic [143:0] out_data_r, out_data_nxt;

  // derived values
  logic [PW-1:0]    pages;
  logic [7:0]       rlen, rper;
  logic             accept, cfg_wr, active;
  logic [2:0]       mode;
  logic [7:0]       dbyte, boff;
  logic [15:0]      off, used;
  logic [8:0]       bir1, slot1;
  logic [PW-1:0]    avail, keep;
  logic [PW:0]      lidx;
  logic [31:0]      fsum;
  logic             pad_go;
  logic [15:0]      pad_used;
  logic             load;
  logic [7:0]       rd_val;

  // memory ports
  logic             mem_we, mem_re;
  logic [ADDRW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_q;

  // remainder unit
  logic            mod_start;
  logic [31:0]     mod_num;
  mod_status_t     mod_st;
  logic [IDXW-1:0] mod_rem;

  function automatic logic [IDXW-1:0] idx_inc(input logic [IDXW-1:0] i,
                                              input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = PW'(i) + PW'(1);
    idx_inc = (s >= p) ? '0 : IDXW'(s);
  endfunction

  function automatic logic [ADDRW-1:0] ring_addr(input logic [IDXW-1:0] i,
                                                 input logic [OFFW-1:0] o);
    ring_addr = ADDRW'(i) * ADDRW'(PAGE_BYTES) + ADDRW'(o);
  endfunction

  assign pages = (rpc_r == 5'd0) ? PW'(1) :
                 ({27'd0, rpc_r} > 32'(MAX_RING_PAGES)) ? PW'(MAX_RING_PAGES) : PW'(rpc_r);
  assign rlen  = (rbytes_r == 8'd0) ? 8'd1 : rbytes_r;
  assign rper  = (rpp_r == 8'd0) ? 8'd1 : rpp_r;

  assign in_tready = (eng_r == ENG_IDLE) && !stale_r && (!out_valid_r || out_tready);
  assign cfg_ready = (eng_r == ENG_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign mode      = in_tuser;
  assign dbyte     = in_tdata[7:0];
  assign boff      = in_tdata[15:8];
  assign active    = (state_r == ST_PAD) || (state_r == ST_DRAIN);

  assign off   = 16'(slot_r) * 16'(rlen) + 16'(bir_r);
  assign bir1  = 9'(bir_r) + 9'd1;
  assign slot1 = 9'(slot_r) + 9'd1;
  assign avail = (head_r >= 32'(pages)) ? pages : PW'(head_r);
  assign keep  = ({27'd0, pre_r} > 32'(avail)) ? avail : PW'(pre_r);
  assign lidx  = ((PW+1)'(hidx_r) >= (PW+1)'(keep)) ?
                 (PW+1)'(hidx_r) - (PW+1)'(keep) :
                 (PW+1)'(hidx_r) + (PW+1)'(pages) - (PW+1)'(keep);
  assign fsum  = flash_r + 32'(PAGE_BYTES);

  // command decode, counter update and memory traffic
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    drain_nxt = drain_r;
    slot_nxt  = slot_r;
    bir_nxt   = bir_r;
    flash_nxt = flash_r;
    drop_nxt  = drop_r;
    fail_nxt  = fail_r;
    total_nxt = total_r;
    hidx_nxt  = hidx_r;
    didx_nxt  = didx_r;
    stale_nxt = stale_r;
    eng_nxt   = eng_r;
    fidx_nxt  = fidx_r;
    flast_nxt = flast_r;
    foff_nxt  = foff_r;
    rdz_nxt   = rdz_r;
    mem_we    = 1'b0;
    mem_waddr = ring_addr(fidx_r, foff_r);
    mem_wdata = FILL_BYTE;
    mem_re    = 1'b0;
    mem_raddr = ring_addr(didx_r, OFFW'(boff));
    mod_start = 1'b0;
    mod_num   = head_r;
    pad_go    = 1'b0;
    pad_used  = 16'd0;

    // configuration side effects
    if (cfg_wr && cfg_index == CFG_POOL_BASE) begin
      flash_nxt = cfg_data;
    end
    if (cfg_wr && cfg_index == CFG_RING_PAGES) begin
      stale_nxt = 1'b1;
    end

    if (accept) begin
      case (mode)
        MODE_START: begin
          head_nxt  = '0;
          drain_nxt = '0;
          slot_nxt  = '0;
          bir_nxt   = '0;
          drop_nxt  = '0;
          fail_nxt  = '0;
          total_nxt = '0;
          hidx_nxt  = '0;
          didx_nxt  = '0;
          state_nxt = ST_PAD;
          fidx_nxt  = '0;
          foff_nxt  = '0;
          flast_nxt = IDXW'(pages - PW'(1));
          eng_nxt   = ENG_FILL;
        end
        MODE_PUSH: begin
          if (active) begin
            if (32'(off) < 32'(PAGE_BYTES)) begin
              mem_we    = 1'b1;
              mem_waddr = ring_addr(hidx_r, OFFW'(off));
              mem_wdata = dbyte;
            end
            bir_nxt = bir1[7:0];
            if (bir1 >= 9'(rlen)) begin
              bir_nxt   = '0;
              slot_nxt  = slot1[7:0];
              total_nxt = total_r + 32'd1;
              if (slot1 >= 9'(rper)) begin
                slot_nxt = '0;
                if (state_r == ST_DRAIN && (head_r + 32'd1 - drain_r) >= 32'(pages)) begin
                  drop_nxt = drop_r + 32'(rper);
                end else begin
                  pad_go   = 1'b1;
                  pad_used = 16'(rper) * 16'(rlen);
                  head_nxt = head_r + 32'd1;
                  hidx_nxt = idx_inc(hidx_r, pages);
                end
              end
            end
          end
        end
        MODE_LAUNCH: begin
          drain_nxt = head_r - 32'(keep);
          didx_nxt  = IDXW'(lidx);
          state_nxt = ST_DRAIN;
        end
        MODE_DONE, MODE_FAIL: begin
          if (mode == MODE_FAIL) begin
            fail_nxt = fail_r + 32'd1;
          end
          drain_nxt = drain_r + 32'd1;
          didx_nxt  = idx_inc(didx_r, pages);
          flash_nxt = (fsum >= pend_r) ? base_r : fsum;
        end
        MODE_FINAL: begin
          if (active) begin
            bir_nxt = '0;
            if (slot_r != 8'd0) begin
              pad_go   = 1'b1;
              pad_used = 16'(slot_r) * 16'(rlen);
              head_nxt = head_r + 32'd1;
              hidx_nxt = idx_inc(hidx_r, pages);
              slot_nxt = '0;
            end
            state_nxt = ST_FINAL;
          end
        end
        MODE_READ: begin
          rdz_nxt = (32'(boff) >= 32'(PAGE_BYTES));
          mem_re  = 1'b1;
          eng_nxt = ENG_RD;
        end
        default: begin
        end
      endcase
      // tail pad of the page just closed
      if (pad_go && 32'(pad_used) < 32'(PAGE_BYTES)) begin
        fidx_nxt  = hidx_r;
        flast_nxt = hidx_r;
        foff_nxt  = OFFW'(pad_used);
        eng_nxt   = ENG_FILL;
      end
    end else begin
      case (eng_r)
        ENG_IDLE: begin
          if (stale_r && !cfg_wr) begin
            eng_nxt = ENG_MODH_G;
          end
        end
        ENG_RD: begin
          eng_nxt = ENG_IDLE;
        end
        ENG_FILL: begin
          mem_we = 1'b1;
          if (foff_r == OFFW'(PAGE_BYTES - 1)) begin
            foff_nxt = '0;
            fidx_nxt = IDXW'(PW'(fidx_r) + PW'(1));
            if (fidx_r == flast_r) begin
              eng_nxt = ENG_IDLE;
            end
          end else begin
            foff_nxt = foff_r + OFFW'(1);
          end
        end
        ENG_MODH_G: begin
          mod_start = 1'b1;
          mod_num   = head_r;
          eng_nxt   = ENG_MODH_W;
        end
        ENG_MODH_W: begin
          if (mod_st.done) begin
            hidx_nxt = mod_rem;
            eng_nxt  = ENG_MODD_G;
          end
        end
        ENG_MODD_G: begin
          mod_start = 1'b1;
          mod_num   = drain_r;
          eng_nxt   = ENG_MODD_W;
        end
        ENG_MODD_W: begin
          if (mod_st.done) begin
            didx_nxt  = mod_rem;
            stale_nxt = 1'b0;
            eng_nxt   = ENG_IDLE;
          end
        end
        default: begin
          eng_nxt = ENG_IDLE;
        end
      endcase
    end
  end

  // result register loading
  always_comb begin
    load   = (accept && mode != MODE_READ) || (eng_r == ENG_RD);
    rd_val = (eng_r == ENG_RD && !rdz_r) ? mem_q : 8'd0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'd0, total_nxt, fail_nxt, drop_nxt, state_nxt, flash_nxt,
                       ((state_nxt == ST_DRAIN || state_nxt == ST_FINAL) &&
                        (drain_nxt < head_nxt)),
                       rd_val};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpc_r       <= 5'd16;
      pre_r       <= 5'd4;
      rbytes_r    <= 8'd25;
      rpp_r       <= 8'd10;
      base_r      <= 32'd0;
      pend_r      <= 32'd1048576;
      state_r     <= ST_IDLE;
      head_r      <= '0;
      drain_r     <= '0;
      slot_r      <= '0;
      bir_r       <= '0;
      flash_r     <= '0;
      drop_r      <= '0;
      fail_r      <= '0;
      total_r     <= '0;
      hidx_r      <= '0;
      didx_r      <= '0;
      stale_r     <= 1'b0;
      eng_r       <= ENG_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_RING_PAGES: rpc_r    <= cfg_data[4:0];
          CFG_PRE_PAGES:  pre_r    <= cfg_data[4:0];
          CFG_REC_BYTES:  rbytes_r <= cfg_data[7:0];
          CFG_RECS_PAGE:  rpp_r    <= cfg_data[7:0];
          CFG_POOL_BASE:  base_r   <= cfg_data;
          CFG_POOL_END:   pend_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      drain_r     <= drain_nxt;
      slot_r      <= slot_nxt;
      bir_r       <= bir_nxt;
      flash_r     <= flash_nxt;
      drop_r      <= drop_nxt;
      fail_r      <= fail_nxt;
      total_r     <= total_nxt;
      hidx_r      <= hidx_nxt;
      didx_r      <= didx_nxt;
      stale_r     <= stale_nxt;
      eng_r       <= eng_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fidx_r     <= fidx_nxt;
    flast_r    <= flast_nxt;
    foff_r     <= foff_nxt;
    rdz_r      <= rdz_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  prl_ring_mem #(
    .PAGE_BYTES    (PAGE_BYTES),
    .MAX_RING_PAGES(MAX_RING_PAGES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_q)
  );

  prl_mod_unit #(
    .MAX_RING_PAGES(MAX_RING_PAGES)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .num   (mod_num),
    .den   (pages),
    .status(mod_st),
    .rem   (mod_rem)
  );

`ifndef SYNTHESIS
  // a non-read transfer always leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode != MODE_READ) |=> out_tvalid)
    else $error("no result after command transfer");

  // after a read transfer the engine is in ENG_RD and no result is shown yet
  a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode == MODE_READ) |=> (eng_r == ENG_RD && !out_tvalid))
    else $error("read not answered in order");

  // ring slots stay inside the pages in use once derived
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (eng_r == ENG_IDLE && !stale_r) |-> (PW'(hidx_r) < pages && PW'(didx_r) < pages))
    else $error("ring slot beyond pages in use");

  // no memory write while a remainder is being worked out
  a_no_write_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_st.busy |-> !mem_we)
    else $error("memory write during slot recompute");
`endif

endmodule
